### hw/rtl/htpp_pkg.sv
// htpp_pkg: shared types and constants for the permuted-probing hash table
// no dependencies; used by htpp_ctrl, htpp_dpath and the top level
`timescale 1ns / 1ps

package htpp_pkg;

	// key geometry
	localparam int KEY_BYTES    = 19;
	localparam int KEY_W        = 8 * KEY_BYTES;
	localparam int SUM_W        = 13;
	localparam int SUM_BYTES    = 20;

	// probe offset register
	localparam int OFFSETS_W     = 48;
	localparam int OFFSET_PROBES = 12;
	localparam logic [OFFSETS_W-1:0] OFFSETS_RESET = 48'd223928981476033;

	// opcodes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_SEARCH = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	// result status codes
	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_DUPLICATE = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_FOUND     = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;
	localparam logic [2:0] ST_DELETED   = 3'd5;

	// controller to datapath
	typedef struct packed {
		logic       capture;
		logic       sum_en;
		logic       mul_en;
		logic       home_en;
		logic       write_slot;
		logic       clear_slot;
		logic       result_en;
		logic [2:0] res_status;
		logic       res_use_slot;
		logic       res_coll;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] op;
		logic       key_absent;
		logic       slot_free;
		logic       slot_match;
	} sts_t;

endpackage

### hw/rtl/hash_table_permuted_probing_core.sv
// hash_table_permuted_probing_core: open-addressing string table, top level
// depends on htpp_pkg, htpp_ctrl and htpp_dpath
//
//   channel   | handshake               | payload
//   ----------+-------------------------+-------------------------------------------
//   command   | start, busy             | opcode, key_bytes_0_7/8_15/16_18
//   result    | done (one-cycle strobe) | status, slot_index, collided
//   config    | probe_offsets_we        | probe_offsets
//
// a word is taken when start is high and busy is low; one result word per command
// empty key or unused opcode: ends at the check in the byte-sum state; otherwise hashing
// (capture, byte sum, reciprocal multiply, residue), then 1 to TABLE_SLOTS probes, one
// slot store read per probe; done follows in the next cycle
// reset empties all slots and loads the default probe offsets; no clearing pass
// done cannot be held off; busy is low again in the cycle done is shown
`timescale 1ns / 1ps

module hash_table_permuted_probing_core #(
	parameter int TABLE_SLOTS = 13
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     opcode,
	input  logic [63:0]                    key_bytes_0_7,
	input  logic [63:0]                    key_bytes_8_15,
	input  logic [23:0]                    key_bytes_16_18,
	output logic                           done,
	output logic [2:0]                     status,
	output logic [3:0]                     slot_index,
	output logic                           collided,
	input  logic                           probe_offsets_we,
	input  logic [htpp_pkg::OFFSETS_W-1:0] probe_offsets
);

	htpp_pkg::cmd_t                 cmd;
	htpp_pkg::sts_t                 sts;
	logic [$clog2(TABLE_SLOTS)-1:0] probe_k;

	// sequencer
	htpp_ctrl #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.sts     (sts),
		.cmd     (cmd),
		.probe_k (probe_k)
	);

	// hash, slot store and result register
	htpp_dpath #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.probe_k          (probe_k),
		.probe_offsets_we (probe_offsets_we),
		.probe_offsets    (probe_offsets),
		.opcode           (opcode),
		.key_bytes_0_7    (key_bytes_0_7),
		.key_bytes_8_15   (key_bytes_8_15),
		.key_bytes_16_18  (key_bytes_16_18),
		.done             (done),
		.status           (status),
		.slot_index       (slot_index),
		.collided         (collided)
	);

endmodule

### hw/rtl/htpp_ctrl.sv
// htpp_ctrl: operation sequencer and probe counter
// depends on htpp_pkg
`timescale 1ns / 1ps

module htpp_ctrl #(
	parameter int TABLE_SLOTS = 13
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  htpp_pkg::sts_t                 sts,
	output htpp_pkg::cmd_t                 cmd,
	output logic [$clog2(TABLE_SLOTS)-1:0] probe_k
);

	localparam int KW = $clog2(TABLE_SLOTS);
	localparam logic [KW-1:0] K_LAST = KW'(TABLE_SLOTS - 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SUM   = 3'd1;
	localparam logic [2:0] S_MUL   = 3'd2;
	localparam logic [2:0] S_HOME  = 3'd3;
	localparam logic [2:0] S_PROBE = 3'd4;

	logic [2:0]    state_q, state_d;
	logic [KW-1:0] k_q, k_d;
	logic          last;

	assign busy    = (state_q != S_IDLE);
	assign probe_k = k_q;
	assign last    = (k_q == K_LAST);

	// state and probe counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_SUM;
				end
			end
			S_SUM: begin
				if (sts.key_absent || sts.op == htpp_pkg::OP_NONE) begin
					cmd.result_en  = 1'b1;
					cmd.res_status = htpp_pkg::ST_NOT_FOUND;
					state_d        = S_IDLE;
				end else begin
					cmd.sum_en = 1'b1;
					state_d    = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = S_HOME;
			end
			S_HOME: begin
				cmd.home_en = 1'b1;
				k_d         = '0;
				state_d     = S_PROBE;
			end
			S_PROBE: begin
				if (sts.op == htpp_pkg::OP_INSERT) begin
					// insert stops at the first empty slot or an equal key
					if (sts.slot_free) begin
						cmd.write_slot   = 1'b1;
						cmd.result_en    = 1'b1;
						cmd.res_status   = htpp_pkg::ST_INSERTED;
						cmd.res_use_slot = 1'b1;
						cmd.res_coll     = (k_q != '0);
						state_d          = S_IDLE;
					end else if (sts.slot_match) begin
						cmd.result_en  = 1'b1;
						cmd.res_status = htpp_pkg::ST_DUPLICATE;
						state_d        = S_IDLE;
					end else if (last) begin
						cmd.result_en  = 1'b1;
						cmd.res_status = htpp_pkg::ST_FULL;
						state_d        = S_IDLE;
					end else begin
						k_d = k_q + 1'b1;
					end
				end else begin
					// search and delete walk past empty slots
					if (sts.slot_match) begin
						cmd.result_en    = 1'b1;
						cmd.res_use_slot = 1'b1;
						if (sts.op == htpp_pkg::OP_DELETE) begin
							cmd.clear_slot = 1'b1;
							cmd.res_status = htpp_pkg::ST_DELETED;
						end else begin
							cmd.res_status = htpp_pkg::ST_FOUND;
						end
						state_d = S_IDLE;
					end else if (last) begin
						cmd.result_en  = 1'b1;
						cmd.res_status = htpp_pkg::ST_NOT_FOUND;
						state_d        = S_IDLE;
					end else begin
						k_d = k_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### hw/rtl/htpp_dpath.sv
// htpp_dpath: key normalize, hash, probe address, slot store and result word
// depends on htpp_pkg
`timescale 1ns / 1ps

module htpp_dpath #(
	parameter int TABLE_SLOTS = 13
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  htpp_pkg::cmd_t                        cmd,
	output htpp_pkg::sts_t                        sts,
	input  logic [$clog2(TABLE_SLOTS)-1:0]        probe_k,
	input  logic                                  probe_offsets_we,
	input  logic [htpp_pkg::OFFSETS_W-1:0]        probe_offsets,
	input  logic [1:0]                            opcode,
	input  logic [63:0]                           key_bytes_0_7,
	input  logic [63:0]                           key_bytes_8_15,
	input  logic [23:0]                           key_bytes_16_18,
	output logic                                  done,
	output logic [2:0]                            status,
	output logic [3:0]                            slot_index,
	output logic                                  collided
);

	localparam int IW       = $clog2(TABLE_SLOTS);
	localparam int KEY_W    = htpp_pkg::KEY_W;
	localparam int SUM_W    = htpp_pkg::SUM_W;
	localparam int RECIP_SH = 20;
	localparam int PROD_W   = SUM_W + RECIP_SH + 1;
	localparam logic [RECIP_SH:0] RECIP =
		(RECIP_SH + 1)'(((1 << RECIP_SH) + TABLE_SLOTS - 1) / TABLE_SLOTS);

	logic [htpp_pkg::OFFSETS_W-1:0] offs_q;
	logic [1:0]                     op_q;
	logic [KEY_W-1:0]               nkey_q;
	logic [SUM_W-1:0]               sum_q;
	logic [SUM_W-1:0]               quo_q;
	logic [IW-1:0]                  home_q;
	logic                           used_q [TABLE_SLOTS];
	logic [KEY_W-1:0]               key_q  [TABLE_SLOTS];
	logic                           done_q;
	logic [2:0]                     status_q;
	logic [3:0]                     slot_q;
	logic                           coll_q;

	logic [KEY_W-1:0]               raw_key;
	logic [KEY_W-1:0]               norm_key;
	logic [htpp_pkg::KEY_BYTES-1:0] nz;
	logic [htpp_pkg::KEY_BYTES-1:0] lowmask;
	logic [8*htpp_pkg::SUM_BYTES-1:0] sum_key;
	logic [7:0]                     sbyte [htpp_pkg::SUM_BYTES];
	logic [9:0]                     gsum  [htpp_pkg::SUM_BYTES / 4];
	logic [SUM_W-1:0]               sum_d;
	logic [PROD_W-1:0]              prod;
	logic [SUM_W-1:0]               rem;
	logic [3:0]                     off_tab [TABLE_SLOTS];
	logic [IW-1:0]                  mod_tab [32];
	logic [4:0]                     psum;
	logic [IW-1:0]                  slot;
	logic [KEY_W-1:0]               rd_key;

	// key ends at its first zero byte
	assign raw_key = {key_bytes_16_18, key_bytes_8_15, key_bytes_0_7};
	always_comb begin
		norm_key = '0;
		for (int i = 0; i < htpp_pkg::KEY_BYTES; i++) begin
			nz[i] = (raw_key[8*i +: 8] != 8'd0);
		end
		for (int i = 0; i < htpp_pkg::KEY_BYTES; i++) begin
			lowmask = htpp_pkg::KEY_BYTES'((20'd1 << (i + 1)) - 20'd1);
			if ((nz & lowmask) == lowmask) begin
				norm_key[8*i +: 8] = raw_key[8*i +: 8];
			end
		end
	end

	// byte sum as a two-level tree, key padded to whole groups of four
	always_comb begin
		sum_key = (8*htpp_pkg::SUM_BYTES)'(nkey_q);
		for (int i = 0; i < htpp_pkg::SUM_BYTES; i++) begin
			sbyte[i] = sum_key[8*i +: 8];
		end
		for (int g = 0; g < htpp_pkg::SUM_BYTES / 4; g++) begin
			gsum[g] = 10'(sbyte[4*g]) + 10'(sbyte[4*g+1])
				+ 10'(sbyte[4*g+2]) + 10'(sbyte[4*g+3]);
		end
		sum_d = '0;
		for (int g = 0; g < htpp_pkg::SUM_BYTES / 4; g++) begin
			sum_d = sum_d + SUM_W'(gsum[g]);
		end
	end

	// sum mod slots via reciprocal multiply, exact over the sum range
	assign prod = PROD_W'(sum_q) * PROD_W'(RECIP);
	assign rem  = sum_q - SUM_W'(quo_q * TABLE_SLOTS);

	// probe offsets and the small mod table for home plus offset
	for (genvar gk = 0; gk < TABLE_SLOTS; gk++) begin : g_off
		if (gk >= 1 && gk <= htpp_pkg::OFFSET_PROBES) begin : g_reg
			assign off_tab[gk] = offs_q[4*(gk-1) +: 4];
		end else begin : g_zero
			assign off_tab[gk] = 4'd0;
		end
	end
	for (genvar gi = 0; gi < 32; gi++) begin : g_mod
		assign mod_tab[gi] = IW'(gi % TABLE_SLOTS);
	end

	assign psum   = 5'(home_q) + 5'(off_tab[probe_k]);
	assign slot   = mod_tab[psum];
	assign rd_key = key_q[slot];

	// status word back to the controller
	assign sts.op         = op_q;
	assign sts.key_absent = (nkey_q[7:0] == 8'd0);
	assign sts.slot_free  = !used_q[slot];
	assign sts.slot_match = used_q[slot] && (rd_key == nkey_q);

	// offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offs_q <= htpp_pkg::OFFSETS_RESET;
		end else if (probe_offsets_we) begin
			offs_q <= probe_offsets;
		end
	end

	// operation word and hash pipeline
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= opcode;
			nkey_q <= norm_key;
		end
		if (cmd.sum_en) begin
			sum_q <= sum_d;
		end
		if (cmd.mul_en) begin
			quo_q <= prod[RECIP_SH +: SUM_W];
		end
		if (cmd.home_en) begin
			home_q <= rem[IW-1:0];
		end
	end

	// slot occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				used_q[i] <= 1'b0;
			end
		end else if (cmd.write_slot) begin
			used_q[slot] <= 1'b1;
		end else if (cmd.clear_slot) begin
			used_q[slot] <= 1'b0;
		end
	end

	// stored keys, only meaningful where the slot is used
	always_ff @(posedge clk) begin
		if (cmd.write_slot) begin
			key_q[slot] <= nkey_q;
		end
	end

	// result word, shown for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.result_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result_en) begin
			status_q <= cmd.res_status;
			slot_q   <= cmd.res_use_slot ? 4'(slot) : 4'd0;
			coll_q   <= cmd.res_coll;
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign slot_index = slot_q;
	assign collided   = coll_q;

endmodule

### test/testbench.sv
// testbench: self-checking bench for hash_table_permuted_probing_core
// depends on htpp_pkg and the core; a directed table of words, then random words
// checked against a local model of the slot store and the probe walk
`timescale 1ns / 1ps

module testbench;

	localparam int SLOTS         = 13;
	localparam int KEY_W         = htpp_pkg::KEY_W;
	localparam int KEY_BYTES     = htpp_pkg::KEY_BYTES;
	localparam int OFFSETS_W     = htpp_pkg::OFFSETS_W;
	localparam int OFFSET_PROBES = htpp_pkg::OFFSET_PROBES;
	localparam int STALL_LIMIT   = 4000;
	localparam int SEGMENTS      = 8;
	localparam int SEG_WORDS     = 45;
	localparam int POOL_KEYS     = 20;
	localparam int DRAIN_CYCLES  = 24;
	localparam int PRINT_CAP     = 200;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] slot;
		logic       coll;
	} probe_result_t;

	typedef struct {
		logic [1:0]       op;
		logic [KEY_W-1:0] key;
		bit               typed;
		probe_result_t    res;
	} directed_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [1:0]           opcode;
	logic [63:0]          key_bytes_0_7;
	logic [63:0]          key_bytes_8_15;
	logic [23:0]          key_bytes_16_18;
	logic                 done;
	logic [2:0]           status;
	logic [3:0]           slot_index;
	logic                 collided;
	logic                 probe_offsets_we;
	logic [OFFSETS_W-1:0] probe_offsets;

	// local copy of the slot store and the offset register
	bit                   slot_used [SLOTS];
	logic [KEY_W-1:0]     slot_key [SLOTS];
	logic [OFFSETS_W-1:0] offsets_now;

	probe_result_t        pending_results [$];
	directed_row_t        directed_rows [$];
	probe_result_t        oldest;
	int                   mismatch_count;
	int                   stall_cycles;

	hash_table_permuted_probing_core #(
		.TABLE_SLOTS(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.key_bytes_0_7(key_bytes_0_7),
		.key_bytes_8_15(key_bytes_8_15),
		.key_bytes_16_18(key_bytes_16_18),
		.done(done),
		.status(status),
		.slot_index(slot_index),
		.collided(collided),
		.probe_offsets_we(probe_offsets_we),
		.probe_offsets(probe_offsets)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// trim the key at its first zero byte, hash it and walk the probe sequence
	function automatic probe_result_t predict_probe_walk(input logic [1:0] op,
			input logic [KEY_W-1:0] raw);
		logic [KEY_W-1:0] key;
		logic             ended;
		logic             walking;
		int unsigned      sum;
		int unsigned      home;
		int unsigned      off;
		int unsigned      s;
		probe_result_t    r;
		key   = '0;
		sum   = 0;
		ended = 1'b0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			if (raw[8*i +: 8] == 8'h00)
				ended = 1'b1;
			if (!ended) begin
				key[8*i +: 8] = raw[8*i +: 8];
				sum += raw[8*i +: 8];
			end
		end
		home    = sum % SLOTS;
		r       = '{htpp_pkg::ST_NOT_FOUND, 4'd0, 1'b0};
		walking = (key[7:0] != 8'h00) && (op != htpp_pkg::OP_NONE);
		if (walking && op == htpp_pkg::OP_INSERT)
			r.status = htpp_pkg::ST_FULL;
		for (int k = 0; k < SLOTS && walking; k++) begin
			off = (k >= 1 && k <= OFFSET_PROBES) ? offsets_now[4*(k-1) +: 4] : 0;
			s   = (home + off) % SLOTS;
			if (op == htpp_pkg::OP_INSERT) begin
				if (!slot_used[s]) begin
					slot_used[s] = 1'b1;
					slot_key[s]  = key;
					r            = '{htpp_pkg::ST_INSERTED, 4'(s), k > 0};
					walking      = 1'b0;
				end else if (slot_key[s] == key) begin
					r.status = htpp_pkg::ST_DUPLICATE;
					walking  = 1'b0;
				end
			end else if (slot_used[s] && slot_key[s] == key) begin
				r.slot  = 4'(s);
				walking = 1'b0;
				if (op == htpp_pkg::OP_SEARCH) begin
					r.status = htpp_pkg::ST_FOUND;
				end else begin
					r.status     = htpp_pkg::ST_DELETED;
					slot_used[s] = 1'b0;
					slot_key[s]  = '0;
				end
			end
		end
		return r;
	endfunction

	// offsets 1..12 in order, or in reverse order
	function automatic logic [OFFSETS_W-1:0] ordered_perm(input bit reversed);
		logic [OFFSETS_W-1:0] v;
		v = '0;
		for (int i = 0; i < OFFSET_PROBES; i++)
			v[4*i +: 4] = reversed ? 4'(OFFSET_PROBES - i) : 4'(i + 1);
		return v;
	endfunction

	function automatic logic [OFFSETS_W-1:0] random_perm();
		logic [3:0]           vals [OFFSET_PROBES];
		logic [3:0]           t;
		int                   j;
		logic [OFFSETS_W-1:0] v;
		for (int i = 0; i < OFFSET_PROBES; i++)
			vals[i] = 4'(i + 1);
		for (int i = OFFSET_PROBES - 1; i > 0; i--) begin
			j       = $urandom_range(i);
			t       = vals[i];
			vals[i] = vals[j];
			vals[j] = t;
		end
		v = '0;
		for (int i = 0; i < OFFSET_PROBES; i++)
			v[4*i +: 4] = vals[i];
		return v;
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want);
		if (mismatch_count < PRINT_CAP)
			$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	task automatic add_row(input logic [1:0] op, input logic [KEY_W-1:0] key, input bit typed,
			input logic [2:0] st, input logic [3:0] sl, input logic co);
		directed_row_t row;
		row.op    = op;
		row.key   = key;
		row.typed = typed;
		row.res   = '{st, sl, co};
		directed_rows.push_back(row);
	endtask

	// drive one command word, with random idle cycles ahead of it
	task automatic send_word(input logic [1:0] op, input logic [KEY_W-1:0] key,
			input int idle_pct, input bit typed, input probe_result_t typed_res);
		probe_result_t predicted;
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start           <= 1'b1;
		opcode          <= op;
		key_bytes_0_7   <= key[63:0];
		key_bytes_8_15  <= key[127:64];
		key_bytes_16_18 <= key[151:128];
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predicted = predict_probe_walk(op, key);
		pending_results.push_back(typed ? typed_res : predicted);
	endtask

	// hold off until every result word is back, then load the offsets
	task automatic write_offsets(input logic [OFFSETS_W-1:0] value);
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		probe_offsets_we <= 1'b1;
		probe_offsets    <= value;
		@(negedge clk);
		probe_offsets_we <= 1'b0;
		offsets_now = value;
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("unexpected result word", 1, 0);
			end else begin
				oldest = pending_results.pop_front();
				if (status !== oldest.status)
					flag_mismatch("status", status, oldest.status);
				if (slot_index !== oldest.slot)
					flag_mismatch("slot_index", slot_index, oldest.slot);
				if (collided !== oldest.coll)
					flag_mismatch("collided", collided, oldest.coll);
			end
		end
	end

	// watchdog on cycles with no word moving either way
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int               idle_pct;
		int               useful;
		int               pick;
		int               len;
		logic [1:0]       op;
		logic [KEY_W-1:0] key;
		logic             ended;
		logic [KEY_W-1:0] key_pool [POOL_KEYS];

		arst_n           = 1'b0;
		start            = 1'b0;
		opcode           = htpp_pkg::OP_INSERT;
		key_bytes_0_7    = '0;
		key_bytes_8_15   = '0;
		key_bytes_16_18  = '0;
		probe_offsets_we = 1'b0;
		probe_offsets    = '0;
		mismatch_count   = 0;
		stall_cycles     = 0;
		offsets_now      = htpp_pkg::OFFSETS_RESET;
		for (int i = 0; i < SLOTS; i++) begin
			slot_used[i] = 1'b0;
			slot_key[i]  = '0;
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed words under the reset offsets; "A" hashes to slot 0, all-ones key to 9
		add_row(htpp_pkg::OP_SEARCH, 152'h41, 1, htpp_pkg::ST_NOT_FOUND, 4'd0, 1'b0);
		add_row(htpp_pkg::OP_DELETE, 152'h41, 1, htpp_pkg::ST_NOT_FOUND, 4'd0, 1'b0);
		add_row(htpp_pkg::OP_INSERT, 152'h41, 1, htpp_pkg::ST_INSERTED, 4'd0, 1'b0);
		add_row(htpp_pkg::OP_INSERT, 152'h41, 1, htpp_pkg::ST_DUPLICATE, 4'd0, 1'b0);
		// bytes past the terminating zero are ignored
		add_row(htpp_pkg::OP_SEARCH, 152'hFFFF_FFFF_FFFF_0041, 1,
			htpp_pkg::ST_FOUND, 4'd0, 1'b0);
		// "N" shares the home slot of "A" and lands further along the walk
		add_row(htpp_pkg::OP_INSERT, 152'h4E, 0, htpp_pkg::ST_INSERTED, 4'd0, 1'b0);
		add_row(htpp_pkg::OP_INSERT, {KEY_W{1'b1}}, 1, htpp_pkg::ST_INSERTED, 4'd9, 1'b0);
		add_row(htpp_pkg::OP_SEARCH, {KEY_W{1'b1}}, 1, htpp_pkg::ST_FOUND, 4'd9, 1'b0);
		// empty key with junk behind it, for insert, search and delete
		add_row(htpp_pkg::OP_INSERT, {{(KEY_W-8){1'b1}}, 8'h00}, 1,
			htpp_pkg::ST_NOT_FOUND, 4'd0, 1'b0);
		add_row(htpp_pkg::OP_SEARCH, {{(KEY_W-8){1'b1}}, 8'h00}, 1,
			htpp_pkg::ST_NOT_FOUND, 4'd0, 1'b0);
		add_row(htpp_pkg::OP_DELETE, {{(KEY_W-8){1'b1}}, 8'h00}, 1,
			htpp_pkg::ST_NOT_FOUND, 4'd0, 1'b0);
		// unused opcode leaves the store alone
		add_row(htpp_pkg::OP_NONE, 152'h41, 1, htpp_pkg::ST_NOT_FOUND, 4'd0, 1'b0);
		add_row(htpp_pkg::OP_SEARCH, 152'h41, 1, htpp_pkg::ST_FOUND, 4'd0, 1'b0);
		add_row(htpp_pkg::OP_DELETE, 152'h41, 1, htpp_pkg::ST_DELETED, 4'd0, 1'b0);
		add_row(htpp_pkg::OP_SEARCH, 152'h4E, 0, htpp_pkg::ST_NOT_FOUND, 4'd0, 1'b0);
		// insert stops at the emptied home slot, so "N" is stored twice
		add_row(htpp_pkg::OP_INSERT, 152'h4E, 1, htpp_pkg::ST_INSERTED, 4'd0, 1'b0);
		add_row(htpp_pkg::OP_DELETE, 152'h4E, 1, htpp_pkg::ST_DELETED, 4'd0, 1'b0);
		add_row(htpp_pkg::OP_SEARCH, 152'h4E, 0, htpp_pkg::ST_NOT_FOUND, 4'd0, 1'b0);
		add_row(htpp_pkg::OP_DELETE, {KEY_W{1'b1}}, 1, htpp_pkg::ST_DELETED, 4'd9, 1'b0);
		add_row(htpp_pkg::OP_SEARCH, {KEY_W{1'b1}}, 1, htpp_pkg::ST_NOT_FOUND, 4'd0, 1'b0);
		// keys ending at the word boundaries and a full-length key
		add_row(htpp_pkg::OP_INSERT, 152'h0807_0605_0403_0201, 0,
			htpp_pkg::ST_INSERTED, 4'd0, 1'b0);
		add_row(htpp_pkg::OP_INSERT,
			{24'h0, 64'h2222_2222_2222_2222, 64'h1111_1111_1111_1111}, 0,
			htpp_pkg::ST_INSERTED, 4'd0, 1'b0);
		add_row(htpp_pkg::OP_INSERT,
			{24'h13_1211, 64'h100F_0E0D_0C0B_0A09, 64'h0807_0605_0403_0201}, 0,
			htpp_pkg::ST_INSERTED, 4'd0, 1'b0);
		add_row(htpp_pkg::OP_SEARCH, 152'h0807_0605_0403_0201, 0,
			htpp_pkg::ST_NOT_FOUND, 4'd0, 1'b0);
		foreach (directed_rows[i])
			send_word(directed_rows[i].op, directed_rows[i].key, 0, directed_rows[i].typed,
				directed_rows[i].res);

		// random segments, each under its own offsets and idle rate
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg)
				0: write_offsets(ordered_perm(1'b0));
				1: write_offsets('0);
				2: write_offsets(random_perm());
				3: write_offsets('1);
				4: write_offsets({16'($urandom), 32'($urandom)});
				5: write_offsets(ordered_perm(1'b1));
				6: write_offsets(random_perm());
				default: write_offsets(htpp_pkg::OFFSETS_RESET);
			endcase
			idle_pct = (seg < 3) ? 14 : (seg < 6) ? 78 : 0;

			// small pool of mostly short keys so homes collide and lookups hit
			for (int p = 0; p < POOL_KEYS; p++) begin
				len = ($urandom_range(3) == 0) ? $urandom_range(KEY_BYTES, 1)
					: $urandom_range(4, 1);
				key_pool[p] = '0;
				for (int i = 0; i < len; i++)
					key_pool[p][8*i +: 8] = 8'($urandom_range(255, 1));
			end

			useful = 0;
			while (useful < SEG_WORDS) begin
				pick = $urandom_range(99);
				key  = key_pool[$urandom_range(POOL_KEYS - 1)];
				if (pick < 6) begin
					key = {24'($urandom), $urandom, $urandom, $urandom, $urandom};
					op  = 2'($urandom);
				end else if (pick < 9) begin
					key = {24'($urandom), $urandom, $urandom, $urandom, 24'($urandom), 8'h00};
					op  = 2'($urandom);
				end else if (pick < 11) begin
					op = htpp_pkg::OP_NONE;
				end else begin
					pick = $urandom_range(99);
					op   = (pick < 45) ? htpp_pkg::OP_INSERT
						: (pick < 70) ? htpp_pkg::OP_SEARCH : htpp_pkg::OP_DELETE;
					// junk after the terminating zero must not change the key
					if ($urandom_range(3) == 0) begin
						ended = 1'b0;
						for (int i = 0; i < KEY_BYTES; i++) begin
							if (ended)
								key[8*i +: 8] = 8'($urandom);
							else if (key[8*i +: 8] == 8'h00)
								ended = 1'b1;
						end
					end
				end
				if (key[7:0] != 8'h00 && op != htpp_pkg::OP_NONE)
					useful++;
				send_word(op, key, idle_pct, 1'b0, '0);
			end
		end

		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/htpp_pkg.sv
hw/rtl/htpp_ctrl.sv
hw/rtl/htpp_dpath.sv
hw/rtl/hash_table_permuted_probing_core.sv
test/testbench.sv
